// ===== rtl/table_linear_interpolation_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TABLE_LINEAR_INTERPOLATION_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/tli_pkg.sv =====
// Package with shared constants, types and helpers for the interpolator.
`timescale 1ns / 1ps
package tli_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = 7;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivCntW = $clog2(DivSteps + 1);

  localparam logic ActLoad = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle, StScan, StFetch, StMul, StStart, StDiv, StOut
  } tli_state_e;

  // Data one cell hands to the next during a scan.
  typedef struct packed {
    logic        found;
    logic [IdxW:0] hit;
  } tli_scan_t;
endpackage

// ===== rtl/tli_cell.sv =====
// One table cell: holds a point and compares it against the scanned query.
`timescale 1ns / 1ps
module tli_cell (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic signed [31:0]      wr_height_i,
  input  logic signed [31:0]      wr_value_i,
  input  logic [tli_pkg::IdxW:0]  my_index_i,
  input  logic                    active_i,
  input  logic signed [31:0]      query_i,
  input  tli_pkg::tli_scan_t      scan_i,
  output tli_pkg::tli_scan_t      scan_o,
  output logic signed [31:0]      height_o,
  output logic signed [31:0]      value_o
);
  import tli_pkg::*;

  logic signed [31:0] height_q;
  logic signed [31:0] value_q;

  // Hold the stored point.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      height_q <= wr_height_i;
      value_q  <= wr_value_i;
    end
  end

  // Pass on the first hit, or claim it when this point lies above the query.
  always_comb begin
    scan_o = scan_i;
    if (!scan_i.found && active_i && (height_q > query_i)) begin
      scan_o.found = 1'b1;
      scan_o.hit   = my_index_i;
    end
  end

  assign height_o = height_q;
  assign value_o  = value_q;
endmodule

// ===== rtl/tli_divider.sv =====
// Restoring divider, one quotient bit per cycle, with round half away.
`timescale 1ns / 1ps
module tli_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [64:0] quot_o
);
  import tli_pkg::*;

  logic [63:0] quot_q, quot_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [34:0] trial;
  logic [34:0] twice_rem;

  // Advance one quotient bit per cycle, then flag done for one cycle.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[63]} - {2'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DivCntW'(DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (!trial[34]) begin
          rem_d = trial[33:0];
          quot_d = {quot_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[32:0], quot_q[63]};
          quot_d = {quot_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  // Round half away from zero on the magnitude.
  assign twice_rem = {rem_q, 1'b0};
  assign quot_o = {1'b0, quot_q} + ((twice_rem >= {2'b0, den_q}) ? 65'd1 : 65'd0);
  assign done_o = busy_q && (cnt_q == '0);
endmodule

// ===== rtl/table_linear_interpolation.sv =====
// Top level: table of cells, scan chain, multiply and divide sequencer.
//  channel | dir | handshake           | payload
//  s_axis  | in  | tvalid/tready       | tdata {query,value,height,index}, tuser action,
//          |     |                     | tlast end_of_column
//  m_axis  | out | tvalid/tready       | tdata {bracket,ovf,value}, tlast column_done
//  cfg     | in  | cfg_we_i            | point_count
// A load is taken while idle; the next request may follow at once.
// A query passes through scan, fetch, multiply, divider start, the
// 64 divider steps and their done flag, and output. Equal bracket
// heights skip the divider. The input is ready again once the result is loaded.
// Reset clears control and point_count (to 2); table entries are unset.
// A stalled result holds in the output register; loads still enter, and a
// following query waits in its output state until the register frees.
`timescale 1ns / 1ps
module table_linear_interpolation (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] point_index, [37:6] point_height, [69:38] point_value,
  // [101:70] query_height, [103:102] zero
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // action
  input  logic         s_axis_tlast,  // end_of_column
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] interp_value, [32] overflow, [38:33] bracket_index, [39] zero
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast,  // column_done
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i
);
  import tli_pkg::*;

  tli_state_e state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [IdxW:0] n_eff;
  logic signed [31:0] query_q;
  logic last_q;
  logic accept;
  logic [IdxW-1:0] lo_q;
  logic signed [31:0] z1_q, z2_q, v1_q, v2_q;
  logic signed [63:0] p1_q, p2_q;
  logic num_neg;
  logic [63:0] num_mag;
  logic [32:0] den_mag;
  logic div_start, div_done;
  logic out_load;
  logic [64:0] div_quot;
  logic out_valid_q;
  logic [31:0] out_val_q;
  logic out_ovf_q;
  logic [IdxW-1:0] out_idx_q;
  logic out_last_q;
  logic [IdxW:0] scan_hit_q;

  tli_scan_t chain [TableDepth+1];
  logic signed [31:0] heights [TableDepth];
  logic signed [31:0] values [TableDepth];

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // Clamp the point count to the table.
  always_comb begin
    if (count_q < CntW'(2)) n_eff = (IdxW+1)'(2);
    else if (count_q > CntW'(TableDepth)) n_eff = (IdxW+1)'(TableDepth);
    else n_eff = count_q[IdxW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= CntW'(2);
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  // Row of cells; the scan flows down the chain.
  assign chain[0] = '{found: 1'b0, hit: n_eff};
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    tli_cell u_cell (
      .clk_i       (clk_i),
      .wr_en_i     (accept && (s_axis_tuser == ActLoad) &&
                    (s_axis_tdata[IdxW-1:0] == IdxW'(g))),
      .wr_height_i (s_axis_tdata[37:6]),
      .wr_value_i  (s_axis_tdata[69:38]),
      .my_index_i  ((IdxW+1)'(g)),
      .active_i    ((IdxW+1)'(g) < n_eff),
      .query_i     (query_q),
      .scan_i      (chain[g]),
      .scan_o      (chain[g+1]),
      .height_o    (heights[g]),
      .value_o     (values[g])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept && s_axis_tuser == ActQuery) state_d = StScan;
      StScan:  state_d = StFetch;
      StFetch: state_d = StMul;
      StMul:   state_d = (z1_q == z2_q) ? StOut : StStart;
      StStart: state_d = StDiv;
      StDiv:   if (div_done) state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    div_start = (state_q == StStart);
    out_load  = (state_q == StOut) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    logic [IdxW:0] hi_full;
    if (accept) begin
      query_q <= s_axis_tdata[101:70];
      last_q  <= s_axis_tlast;
    end
    if (state_q == StScan) begin
      scan_hit_q <= chain[TableDepth].hit;
    end
    if (state_q == StFetch) begin
      hi_full = scan_hit_q;
      if (hi_full == '0) begin
        lo_q <= '0;
        z1_q <= heights[0]; z2_q <= heights[1];
        v1_q <= values[0];  v2_q <= values[1];
      end else if (hi_full >= n_eff) begin
        lo_q <= IdxW'(n_eff - 2);
        z1_q <= heights[IdxW'(n_eff - 2)]; z2_q <= heights[IdxW'(n_eff - 1)];
        v1_q <= values[IdxW'(n_eff - 2)];  v2_q <= values[IdxW'(n_eff - 1)];
      end else begin
        lo_q <= IdxW'(hi_full - 1);
        z1_q <= heights[IdxW'(hi_full - 1)]; z2_q <= heights[IdxW'(hi_full)];
        v1_q <= values[IdxW'(hi_full - 1)];  v2_q <= values[IdxW'(hi_full)];
      end
    end
    if (state_q == StMul) begin
      p1_q <= 64'(v1_q * ($signed({z2_q[31], z2_q}) - $signed({query_q[31], query_q})));
      p2_q <= 64'(v2_q * ($signed({query_q[31], query_q}) - $signed({z1_q[31], z1_q})));
    end
    if (out_load) begin
      out_idx_q  <= lo_q;
      out_last_q <= last_q;
      if (z1_q == z2_q) begin
        out_val_q <= v1_q;
        out_ovf_q <= 1'b0;
      end else if (num_neg) begin
        out_ovf_q <= div_quot > 65'h80000000;
        out_val_q <= (div_quot > 65'h80000000) ? 32'h80000000 : 32'(-div_quot);
      end else begin
        out_ovf_q <= div_quot > 65'h7FFFFFFF;
        out_val_q <= (div_quot > 65'h7FFFFFFF) ? 32'h7FFFFFFF : div_quot[31:0];
      end
    end
  end

  // Sign and magnitude of the numerator and divisor.
  always_comb begin
    logic signed [64:0] sum;
    logic signed [32:0] dd;
    sum = {p1_q[63], p1_q} + {p2_q[63], p2_q};
    dd = {z2_q[31], z2_q} - {z1_q[31], z1_q};
    num_neg = sum[64] ^ dd[32];
    num_mag = sum[64] ? 64'(-sum) : sum[63:0];
    den_mag = dd[32] ? 33'(-dd) : dd;
  end

  tli_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Output register: hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_idx_q, out_ovf_q, out_val_q};
  assign m_axis_tlast  = out_last_q;
endmodule

// ===== rtl/tli_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
`timescale 1ns / 1ps
`include "table_linear_interpolation_macros.svh"
module tli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import tli_pkg::*;
  `TLI_ASSERT_NEXT(a_load_ready, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ActLoad, s_axis_tready)
  `TLI_ASSERT_NEXT(a_query_busy, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ActQuery, !s_axis_tready)
  `TLI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
  `TLI_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[39] == 1'b0)
endmodule

bind table_linear_interpolation tli_checker u_tli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/table_linear_interpolation_tb.sv =====
// Self-checking testbench for the table interpolator: loads, queries, point_count settings.
`timescale 1ns / 1ps
module table_linear_interpolation_tb;
  import tli_pkg::*;

  typedef struct packed {
    logic        act;
    logic [5:0]  idx;
    logic [31:0] hgt;
    logic [31:0] val;
    logic [31:0] qz;
    logic        eoc;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
    logic [5:0]  bracket;
    logic        done;
  } interp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [6:0]   cfg_wdata_i = '0;

  req_t    pending_q[$];
  interp_t interp_q[$];
  logic signed [31:0] heights[TableDepth];
  logic signed [31:0] values[TableDepth];
  logic [6:0] count_reg = 7'd2;
  int  err_cnt = 0;
  int  idle_cnt = 0;
  bit  calm = 1'b0;
  bit  done_flag = 1'b0;

  table_linear_interpolation u_top (.*);

  always #5 clk_i = ~clk_i;

  // Expected output of a query against the current table copy.
  function automatic interp_t interpolate(req_t r);
    interp_t o;
    int n, hi, lo, k;
    longint z, z1, z2, v1, v2;
    n = (count_reg < 2) ? 2 : (count_reg > TableDepth) ? TableDepth : count_reg;
    z = longint'($signed(r.qz));
    hi = n;
    for (k = n - 1; k >= 0; k--) if (longint'(heights[k]) > z) hi = k;
    if (hi == 0) begin
      lo = 0; hi = 1;
    end else if (hi >= n) begin
      lo = n - 2; hi = n - 1;
    end else begin
      lo = hi - 1;
    end
    z1 = heights[lo]; z2 = heights[hi]; v1 = values[lo]; v2 = values[hi];
    o.ovf = 1'b0;
    if (z1 == z2) begin
      o.value = v1[31:0];
    end else begin
      // products fit in 64 bits; the sum may not, so work in 128
      begin
        logic signed [127:0] s, sm, qq, rr, dd;
        s = 128'(v1) * 128'(z2 - z) + 128'(v2) * 128'(z - z1);
        dd = 128'(z2 - z1);
        sm = (s < 0) ? -s : s;
        if (dd < 0) dd = -dd;
        qq = sm / dd;
        rr = sm % dd;
        if (2 * rr >= dd) qq = qq + 1;
        if ((s < 0) != ((z2 - z1) < 0)) begin
          if (qq > 128'sh80000000) begin qq = 128'sh80000000; o.ovf = 1'b1; end
          qq = -qq;
        end else if (qq > 128'sh7FFFFFFF) begin
          qq = 128'sh7FFFFFFF; o.ovf = 1'b1;
        end
        o.value = qq[31:0];
      end
    end
    o.bracket = lo[5:0];
    o.done = r.eoc;
    return o;
  endfunction

  // Append one request to the pending queue.
  task automatic add_req(req_t r);
    pending_q = {pending_q, r};
  endtask

  function automatic req_t mk_load(int i, logic [31:0] h, logic [31:0] v);
    req_t r = '0;
    r.act = ActLoad; r.idx = i[5:0]; r.hgt = h; r.val = v;
    r.qz = $urandom; r.eoc = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t mk_query(logic [31:0] z, logic e);
    req_t r = '0;
    r.act = ActQuery; r.qz = z; r.eoc = e;
    r.idx = 6'($urandom); r.hgt = $urandom; r.val = $urandom;
    return r;
  endfunction

  // Idle roughly 28 percent of cycles, except during the calm stretch.
  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 28);
  endfunction

  // Driver: present pending requests and update the table copy on accept.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req_t r;
        r = pending_q.pop_front();
        if (r.act == ActLoad) begin
          heights[r.idx] = r.hgt; values[r.idx] = r.val;
        end else begin
          interp_q = {interp_q, interpolate(r)};
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && !take_gap()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b0, pending_q[0].qz, pending_q[0].val, pending_q[0].hgt,
                           pending_q[0].idx};
          s_axis_tuser <= pending_q[0].act;
          s_axis_tlast <= pending_q[0].eoc;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        interp_t e;
        idle_cnt <= 0;
        if (interp_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          err_cnt++;
        end else begin
          e = interp_q.pop_front();
          if (m_axis_tdata[31:0] !== e.value) begin
            $error("interp_value exp %h got %h", e.value, m_axis_tdata[31:0]); err_cnt++;
          end
          if (m_axis_tdata[32] !== e.ovf) begin
            $error("overflow exp %b got %b", e.ovf, m_axis_tdata[32]); err_cnt++;
          end
          if (m_axis_tdata[38:33] !== e.bracket) begin
            $error("bracket_index exp %0d got %0d", e.bracket, m_axis_tdata[38:33]);
            err_cnt++;
          end
          if (m_axis_tlast !== e.done) begin
            $error("column_done exp %b got %b", e.done, m_axis_tlast); err_cnt++;
          end
        end
      end else if (s_axis_tvalid && s_axis_tready) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      m_axis_tready <= !take_gap();
    end
  end

  // Watchdog: end with an error when neither interface moves before the idle limit.
  always @(posedge clk_i) begin
    if (idle_cnt > 5000 && !done_flag) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid || interp_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] c);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = c;
  endtask

  // Load a sorted (mostly) table of n points with random content.
  task automatic load_table(int n, bit wide);
    int i;
    logic signed [31:0] h;
    h = wide ? -32'sd2000000000 + $urandom_range(0, 1000) : $signed($urandom_range(0, 4000)) - 2000;
    for (i = 0; i < n; i++) begin
      add_req(mk_load(i, h, wide ? $urandom : $urandom_range(0, 200000) - 100000));
      if ($urandom_range(0, 9) == 0) h = h;           // equal heights now and then
      else h = h + (wide ? $urandom_range(1, 60000000) : $urandom_range(1, 600));
    end
  endtask

  initial begin
    int i, ph, n, k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes with reset point_count of 2
    add_req(mk_load(0, 32'h8000_0000, 32'h7FFF_FFFF));
    add_req(mk_load(1, 32'h7FFF_FFFF, 32'h8000_0000));
    add_req(mk_query(32'h8000_0000, 1'b0));
    add_req(mk_query(32'h7FFF_FFFF, 1'b1));
    add_req(mk_query(32'h0000_0000, 1'b0));
    add_req(mk_load(63, 32'h0000_0100, 32'hFFFF_FFFF));
    add_req(mk_load(1, 32'h8000_0000, 32'h1234_5678));   // equal heights
    add_req(mk_query(32'h0, 1'b1));
    add_req(mk_load(0, 32'h0, 32'h7FFF_FFFF));
    add_req(mk_load(1, 32'h1, 32'h8000_0000));           // steep: saturates
    add_req(mk_query(32'h7FFF_FFFF, 1'b0));
    add_req(mk_query(32'h8000_0000, 1'b1));
    add_req(mk_load(1, 32'hFFFF_FFFF, 32'h0));            // unsorted pair
    add_req(mk_query(32'h5, 1'b0));
    wait_drained();
    // random phases across point_count settings, extremes included
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 2; 1: n = 64; 2: n = 0; 3: n = 127; 4: n = 1;
        default: n = $urandom_range(2, 64);
      endcase
      write_count(n[6:0]);
      calm = (ph == 5);
      k = (n < 2) ? 2 : (n > 64 ? 64 : n);
      load_table(k, ph[0]);
      for (i = 0; i < 75; i++) begin
        if ($urandom_range(0, 19) == 0)
          add_req(mk_load($urandom_range(0, k - 1), $urandom, $urandom));
        else if ($urandom_range(0, 3) == 0)
          add_req(mk_query($urandom, 1'($urandom_range(0, 1))));
        else
          add_req(mk_query(heights_hint(k) + $urandom_range(0, 200) - 100,
                           1'($urandom_range(0, 1))));
      end
      wait_drained();
    end
    done_flag = 1'b1;
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Height near a random loaded point, from the table as queued.
  function automatic logic [31:0] heights_hint(int k);
    int j;
    j = $urandom_range(0, k - 1);
    for (int m = pending_q.size() - 1; m >= 0; m--)
      if (pending_q[m].act == ActLoad && pending_q[m].idx == j) return pending_q[m].hgt;
    return heights[j];
  endfunction
endmodule
